FILE: rtl/core/smoothed_coeff_biquad_filter_macros.svh
// ----------------------------------------------------------------------------
// Smoothed-coefficient biquad filter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_COEFF_BIQUAD_FILTER_MACROS_SVH
`define SMOOTHED_COEFF_BIQUAD_FILTER_MACROS_SVH

// Same-cycle implication.
`define SCBQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scbq: same-cycle check failed");

// Next-cycle implication.
`define SCBQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scbq: next-cycle check failed");

`endif

FILE: rtl/core/scbq_pkg.sv
// ----------------------------------------------------------------------------
// Smoothed-coefficient biquad filter package
// Default widths, register indexes, microcode word and control types.
// ----------------------------------------------------------------------------
package scbq_pkg;

  // Default configuration of the top level.
  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int DEF_COEFF_WIDTH  = 27;
  localparam int DEF_SMOOTH_BITS  = 16;

  // Retention value after reset.
  localparam int SMOOTH_RESET = 65470;

  // Coefficient bank: b0 b1 b2 a1 a2.
  localparam int NUM_COEFFS = 5;
  localparam int COEF_SEL_W = 3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_A2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 3'd5;

  // Coefficient slots in the bank.
  localparam logic [COEF_SEL_W-1:0] COEF_B0 = 3'd0;
  localparam logic [COEF_SEL_W-1:0] COEF_B1 = 3'd1;
  localparam logic [COEF_SEL_W-1:0] COEF_B2 = 3'd2;
  localparam logic [COEF_SEL_W-1:0] COEF_A1 = 3'd3;
  localparam logic [COEF_SEL_W-1:0] COEF_A2 = 3'd4;

  // Microprogram addressing.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] STEP_OUT  = 5'd17;

  typedef enum logic [1:0] {
    MUL_NONE  = 2'd0,
    MUL_GLIDE = 2'd1,
    MUL_FILT  = 2'd2
  } mul_op_e;

  typedef enum logic [2:0] {
    SRC_X  = 3'd0,
    SRC_X1 = 3'd1,
    SRC_X2 = 3'd2,
    SRC_Y1 = 3'd3,
    SRC_Y2 = 3'd4
  } src_e;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NONE     = 2'd0,
    JMP_NO_INPUT = 2'd1,
    JMP_OUT_BUSY = 2'd2,
    JMP_ALWAYS   = 2'd3
  } jmp_cond_e;

  // One microcode control word.
  typedef struct packed {
    mul_op_e                 mul_op;
    logic [COEF_SEL_W-1:0]   coef_sel;
    src_e                    src;
    logic                    upd_en;
    acc_op_e                 acc_op;
    logic                    take_in;
    logic                    out_load;
    jmp_cond_e               jmp;
    logic [STEP_W-1:0]       jmp_target;
    logic                    last;
  } ucode_t;

  // Datapath controls issued by the sequencer.
  typedef struct packed {
    mul_op_e                 mul_op;
    logic [COEF_SEL_W-1:0]   coef_sel;
    src_e                    src;
    logic                    upd_en;
    acc_op_e                 acc_op;
    logic                    fire_in;
    logic                    fire_out;
  } ctl_t;

endpackage

FILE: rtl/core/scbq_ucode_rom.sv
// ----------------------------------------------------------------------------
// Microcode ROM
// The per-sample program: glide five coefficients, five MACs, output.
// ----------------------------------------------------------------------------
module scbq_ucode_rom (
  input  logic [scbq_pkg::STEP_W-1:0] step_i,
  output scbq_pkg::ucode_t            word_o
);
  import scbq_pkg::*;

  // Plain datapath step that falls through to the next address.
  function automatic ucode_t op_word(mul_op_e m, logic [COEF_SEL_W-1:0] c, src_e s,
                                     logic u, acc_op_e a);
    ucode_t w;
    w            = '0;
    w.mul_op     = m;
    w.coef_sel   = c;
    w.src        = s;
    w.upd_en     = u;
    w.acc_op     = a;
    w.jmp        = JMP_NONE;
    w.jmp_target = STEP_IDLE;
    return w;
  endfunction

  always_comb begin
    word_o            = '0;
    word_o.jmp        = JMP_ALWAYS;
    word_o.jmp_target = STEP_IDLE;
    unique case (step_i)
      // Wait for a sample request.
      5'd0: begin
        word_o            = op_word(MUL_NONE, COEF_B0, SRC_X, 1'b0, ACC_NONE);
        word_o.take_in    = 1'b1;
        word_o.jmp        = JMP_NO_INPUT;
        word_o.jmp_target = STEP_IDLE;
      end
      // Smoother: product step, then update step, per coefficient.
      5'd1:  word_o = op_word(MUL_GLIDE, COEF_B0, SRC_X, 1'b0, ACC_NONE);
      5'd2:  word_o = op_word(MUL_NONE,  COEF_B0, SRC_X, 1'b1, ACC_NONE);
      5'd3:  word_o = op_word(MUL_GLIDE, COEF_B1, SRC_X, 1'b0, ACC_NONE);
      5'd4:  word_o = op_word(MUL_NONE,  COEF_B1, SRC_X, 1'b1, ACC_NONE);
      5'd5:  word_o = op_word(MUL_GLIDE, COEF_B2, SRC_X, 1'b0, ACC_NONE);
      5'd6:  word_o = op_word(MUL_NONE,  COEF_B2, SRC_X, 1'b1, ACC_NONE);
      5'd7:  word_o = op_word(MUL_GLIDE, COEF_A1, SRC_X, 1'b0, ACC_NONE);
      5'd8:  word_o = op_word(MUL_NONE,  COEF_A1, SRC_X, 1'b1, ACC_NONE);
      5'd9:  word_o = op_word(MUL_GLIDE, COEF_A2, SRC_X, 1'b0, ACC_NONE);
      5'd10: word_o = op_word(MUL_NONE,  COEF_A2, SRC_X, 1'b1, ACC_NONE);
      // Filter: each product is accumulated in the step after it is formed.
      5'd11: word_o = op_word(MUL_FILT,  COEF_B0, SRC_X,  1'b0, ACC_NONE);
      5'd12: word_o = op_word(MUL_FILT,  COEF_B1, SRC_X1, 1'b0, ACC_LOAD);
      5'd13: word_o = op_word(MUL_FILT,  COEF_B2, SRC_X2, 1'b0, ACC_ADD);
      5'd14: word_o = op_word(MUL_FILT,  COEF_A1, SRC_Y1, 1'b0, ACC_ADD);
      5'd15: word_o = op_word(MUL_FILT,  COEF_A2, SRC_Y2, 1'b0, ACC_SUB);
      5'd16: word_o = op_word(MUL_NONE,  COEF_B0, SRC_X,  1'b0, ACC_SUB);
      // Round, saturate and load the output once the output slot is free.
      5'd17: begin
        word_o            = op_word(MUL_NONE, COEF_B0, SRC_X, 1'b0, ACC_NONE);
        word_o.out_load   = 1'b1;
        word_o.jmp        = JMP_OUT_BUSY;
        word_o.jmp_target = STEP_OUT;
        word_o.last       = 1'b1;
      end
      default: begin
        word_o            = '0;
        word_o.jmp        = JMP_ALWAYS;
        word_o.jmp_target = STEP_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/scbq_sequencer.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter with conditional jumps; turns control words into strobes.
// ----------------------------------------------------------------------------
module scbq_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_busy_i,
  output scbq_pkg::ctl_t  ctl_o
);
  import scbq_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            word;
  logic              jump;

  scbq_ucode_rom u_rom (
    .step_i (step_q),
    .word_o (word)
  );

  // Jump condition of the current word.
  always_comb begin
    unique case (word.jmp)
      JMP_NONE:     jump = 1'b0;
      JMP_NO_INPUT: jump = !in_valid_i;
      JMP_OUT_BUSY: jump = out_busy_i;
      JMP_ALWAYS:   jump = 1'b1;
      default:      jump = 1'b1;
    endcase
  end

  // Next program address.
  always_comb begin
    if (jump) begin
      step_d = word.jmp_target;
    end else if (word.last) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Strobes toward the datapath.
  assign in_ready_o     = word.take_in;
  assign ctl_o.mul_op   = word.mul_op;
  assign ctl_o.coef_sel = word.coef_sel;
  assign ctl_o.src      = word.src;
  assign ctl_o.upd_en   = word.upd_en;
  assign ctl_o.acc_op   = word.acc_op;
  assign ctl_o.fire_in  = word.take_in && in_valid_i;
  assign ctl_o.fire_out = word.out_load && !out_busy_i;

endmodule

FILE: rtl/core/scbq_datapath.sv
// ----------------------------------------------------------------------------
// Filter datapath
// Coefficient bank, histories, shared multiplier, accumulator and output.
// ----------------------------------------------------------------------------
`include "smoothed_coeff_biquad_filter_macros.svh"

module scbq_datapath #(
  parameter int SAMPLE_WIDTH = scbq_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEFF_WIDTH  = scbq_pkg::DEF_COEFF_WIDTH,
  parameter int SMOOTH_BITS  = scbq_pkg::DEF_SMOOTH_BITS,
  parameter int CFG_W        = (COEFF_WIDTH > SMOOTH_BITS + 1) ? COEFF_WIDTH
                                                               : SMOOTH_BITS + 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  scbq_pkg::ctl_t                   ctl_i,
  input  logic                             cfg_we_i,
  input  logic [scbq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]                 cfg_wdata_i,
  input  logic [SAMPLE_WIDTH-1:0]          sample_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [SAMPLE_WIDTH-1:0]          sample_o,
  output logic                             out_busy_o
);
  import scbq_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COEFF_WIDTH;
  localparam int SB    = SMOOTH_BITS;
  localparam int CF    = CW - 5;
  localparam int BW    = (SW > SB + 2) ? SW : SB + 2;
  localparam int AW    = CW + 2;
  localparam int PW    = AW + BW;
  localparam int ACC_W = CW + SW + 3;

  localparam logic [SB:0]              S_ONE     = (SB + 1)'(1) << SB;
  localparam logic [PW-1:0]            GLIDE_RND = PW'(S_ONE - (SB + 1)'(1));
  localparam logic signed [ACC_W-1:0]  ROUND_C   = ACC_W'(64'sd1 <<< (CF - 1));
  localparam logic signed [ACC_W-1:0]  SAT_MAX   = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0]  SAT_MIN   = -SAT_MAX - ACC_W'(1);
  localparam logic signed [CW-1:0]     COEF_ONE  = CW'(64'sd1 <<< CF);

  // Configuration and filter state.
  logic signed [CW-1:0] target_q [NUM_COEFFS];
  logic        [SB:0]   smooth_q;
  logic signed [CW-1:0] coeff_q  [NUM_COEFFS];
  logic signed [SW-1:0] x_q, x1_q, x2_q, y1_q, y2_q;

  // Arithmetic registers.
  logic signed [PW-1:0]    prod_q;
  logic                    neg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    out_valid_q;
  logic        [SW-1:0]    out_q;

  logic signed [CW-1:0]    cur, tgt;
  logic        [SB:0]      keep, one_minus;
  logic signed [CW:0]      diff;
  logic        [CW:0]      mag;
  logic signed [SW-1:0]    src_sample;
  logic signed [AW-1:0]    mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;
  logic        [PW-1:0]    step_sum;
  logic        [CW:0]      step_mag, cur_ext, new_w;
  logic signed [ACC_W-1:0] prod_ext, rnd, y_full;
  logic signed [SW-1:0]    sat_y;

  // Operand fetch for the selected coefficient.
  assign cur       = coeff_q[ctl_i.coef_sel];
  assign tgt       = target_q[ctl_i.coef_sel];
  assign keep      = (smooth_q > S_ONE) ? S_ONE : smooth_q;
  assign one_minus = S_ONE - keep;
  assign diff      = (CW + 1)'(tgt) - (CW + 1)'(cur);
  assign mag       = diff[CW] ? (CW + 1)'(-diff) : (CW + 1)'(diff);

  always_comb begin
    unique case (ctl_i.src)
      SRC_X:   src_sample = x_q;
      SRC_X1:  src_sample = x1_q;
      SRC_X2:  src_sample = x2_q;
      SRC_Y1:  src_sample = y1_q;
      SRC_Y2:  src_sample = y2_q;
      default: src_sample = x_q;
    endcase
  end

  // Shared multiplier operands: glide magnitude times (1 - s), or coefficient
  // times a sample.
  always_comb begin
    if (ctl_i.mul_op == MUL_GLIDE) begin
      mul_a = $signed({1'b0, mag});
      mul_b = BW'($signed({1'b0, one_minus}));
    end else begin
      mul_a = AW'(cur);
      mul_b = BW'(src_sample);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Smoother update: step magnitude rounded up, applied toward the target.
  assign step_sum = prod_q + GLIDE_RND;
  assign step_mag = step_sum[SB +: CW + 1];
  assign cur_ext  = (CW + 1)'(cur);
  assign new_w    = neg_q ? (cur_ext - step_mag) : (cur_ext + step_mag);

  // Output rounding to nearest, ties up, then saturation.
  assign prod_ext = ACC_W'(prod_q);
  assign rnd      = acc_q + ROUND_C;
  assign y_full   = rnd >>> CF;

  always_comb begin
    if (y_full > SAT_MAX) begin
      sat_y = SW'(SAT_MAX);
    end else if (y_full < SAT_MIN) begin
      sat_y = SW'(SAT_MIN);
    end else begin
      sat_y = SW'(y_full);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        target_q[i] <= (i == int'(COEF_B0)) ? COEF_ONE : '0;
      end
      smooth_q <= (SB + 1)'(SMOOTH_RESET);
    end else if (cfg_we_i) begin
      if (cfg_idx_i < REG_SMOOTHING) begin
        target_q[cfg_idx_i] <= cfg_wdata_i[CW-1:0];
      end else if (cfg_idx_i == REG_SMOOTHING) begin
        smooth_q <= cfg_wdata_i[SB:0];
      end
    end
  end

  // Working coefficients.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        coeff_q[i] <= (i == int'(COEF_B0)) ? COEF_ONE : '0;
      end
    end else if (ctl_i.upd_en) begin
      coeff_q[ctl_i.coef_sel] <= new_w[CW-1:0];
    end
  end

  // Histories shift when the result is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (ctl_i.fire_out) begin
      x1_q <= x_q;
      x2_q <= x1_q;
      y1_q <= sat_y;
      y2_q <= y1_q;
    end
  end

  // Product, accumulator and sample registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.fire_in) begin
      x_q <= sample_i;
    end
    if (ctl_i.mul_op != MUL_NONE) begin
      prod_q <= mul_p;
      neg_q  <= diff[CW];
    end
    unique case (ctl_i.acc_op)
      ACC_NONE: acc_q <= acc_q;
      ACC_LOAD: acc_q <= prod_ext;
      ACC_ADD:  acc_q <= acc_q + prod_ext;
      ACC_SUB:  acc_q <= acc_q - prod_ext;
      default:  acc_q <= acc_q;
    endcase
    if (ctl_i.fire_out) begin
      out_q <= sat_y;
    end
  end

  // Output request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.fire_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q;
  assign out_busy_o  = out_valid_q && !out_ready_i;

  `SCBQ_ASSERT_NEXT(a_load_sets_valid, ctl_i.fire_out, out_valid_q && (out_q == $past(sat_y)))
  `SCBQ_ASSERT_IMP(a_in_out_exclusive, ctl_i.fire_out, !ctl_i.fire_in)
  `SCBQ_ASSERT_NEXT(a_history_shift, ctl_i.fire_out, x1_q == $past(x_q))

endmodule

FILE: rtl/core/smoothed_coeff_biquad_filter.sv
// One sample is processed at a time: a new sample request is taken only after
// the 18-step microprogram, which shares one multiplier, has loaded the result
// of the last one, and the sequencer waits while the output slot is busy.
// Reset (asynchronous, active low) sets b0 to 1.0, the other coefficients,
// both input and output histories to zero, and the targets and retention
// registers to their defaults.
// ----------------------------------------------------------------------------
// Smoothed-coefficient biquad filter
// Direct-form-1 biquad whose coefficients glide toward their targets.
// ----------------------------------------------------------------------------
module smoothed_coeff_biquad_filter #(
  parameter int SAMPLE_WIDTH = scbq_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEFF_WIDTH  = scbq_pkg::DEF_COEFF_WIDTH,
  parameter int SMOOTH_BITS  = scbq_pkg::DEF_SMOOTH_BITS,
  parameter int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int CFG_W        = (COEFF_WIDTH > SMOOTH_BITS + 1) ? COEFF_WIDTH
                                                               : SMOOTH_BITS + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input samples.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [DATA_W-1:0]              s_axis_tdata,   // sample_in
  // Filtered samples.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [DATA_W-1:0]              m_axis_tdata,   // sample_out
  // Register writes.
  input  logic                           cfg_we_i,
  input  logic [scbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_wdata_i
);
  import scbq_pkg::*;

  ctl_t                    ctl;
  logic                    out_busy;
  logic [SAMPLE_WIDTH-1:0] sample_out;

  scbq_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (out_busy),
    .ctl_o      (ctl)
  );

  scbq_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEFF_WIDTH  (COEFF_WIDTH),
    .SMOOTH_BITS  (SMOOTH_BITS),
    .CFG_W        (CFG_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sample_o    (sample_out),
    .out_busy_o  (out_busy)
  );

  // Result padded with zeros to whole bytes.
  assign m_axis_tdata = DATA_W'(sample_out);

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Smoothed-coefficient biquad filter testbench
// Streams samples through the filter and compares every output with a
// fixed-point prediction. The prediction runs the coefficient glide, the
// direct-form-1 sum, rounding and saturation. The run covers directed corner
// cases and then random coefficient settings, with random stalls on both
// sides.
// ----------------------------------------------------------------------------
module testbench;
  import scbq_pkg::*;

  localparam int SAMPLE_W   = DEF_SAMPLE_WIDTH;
  localparam int COEFF_W    = DEF_COEFF_WIDTH;
  localparam int SMOOTH_W   = DEF_SMOOTH_BITS;
  localparam int DATA_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int CFG_W      = (COEFF_W > SMOOTH_W + 1) ? COEFF_W : SMOOTH_W + 1;
  localparam int COEFF_FRAC = COEFF_W - 5;

  localparam longint S_ONE      = longint'(1) << SMOOTH_W;
  localparam longint RETAIN_TOP = (longint'(1) << (SMOOTH_W + 1)) - 1;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint COEF_MAX   = (longint'(1) << (COEFF_W - 1)) - 1;
  localparam longint COEF_MIN   = -COEF_MAX - 1;
  localparam longint COEF_ONE   = longint'(1) << COEFF_FRAC;
  localparam longint SAMPLE_ONE = longint'(1) << (SAMPLE_W - 2);

  // Register indexes that map to no register.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam int LATENCY      = 17;
  localparam int LONG_HOLD    = 600;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1450;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]  coef_t;
  typedef logic [CFG_W-1:0]           cfg_word_t;

  // Block ports.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;   // sample_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;         // sample_out
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  cfg_word_t            cfg_wdata_i   = '0;

  smoothed_coeff_biquad_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Filter state mirrored by the predictor.
  longint target_coef [NUM_COEFFS];
  longint glide_coef  [NUM_COEFFS];
  longint retention;
  longint x_hist [2];
  longint y_hist [2];

  logic [SAMPLE_W-1:0] pending_samples [$];
  sample_t             expected_outputs [$];

  int unsigned samples_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned saturated_count = 0;
  int unsigned settings_count  = 0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  int unsigned hold_left       = 0;
  int unsigned taken_count     = 0;
  int unsigned idle_cycles     = 0;
  bit          long_hold_done  = 1'b0;
  bit          next_valid;

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_filter_state();
    for (int i = 0; i < NUM_COEFFS; i++) begin
      target_coef[i] = 0;
      glide_coef[i]  = 0;
    end
    target_coef[COEF_B0] = COEF_ONE;
    glide_coef[COEF_B0]  = COEF_ONE;
    retention = SMOOTH_RESET;
    x_hist = '{0, 0};
    y_hist = '{0, 0};
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t val);
    coef_t c;
    c = val[COEFF_W-1:0];
    if (idx <= REG_TARGET_A2) begin
      target_coef[idx] = c;
    end else if (idx == REG_SMOOTHING) begin
      retention = val[SMOOTH_W:0];
    end
  endfunction

  // One smoother step; the step magnitude rounds up so the target is reached.
  function automatic longint glide_step(longint cur, longint tgt, longint keep);
    longint diff;
    longint mag;
    longint stepv;
    diff  = tgt - cur;
    mag   = (diff < 0) ? -diff : diff;
    stepv = (mag * (S_ONE - keep) + S_ONE - 1) >>> SMOOTH_W;
    return (diff < 0) ? cur - stepv : cur + stepv;
  endfunction

  function automatic sample_t filter_sample(sample_t x);
    longint keep;
    longint xv;
    longint acc;
    longint y;
    keep = (retention > S_ONE) ? S_ONE : retention;
    xv   = x;
    for (int i = 0; i < NUM_COEFFS; i++) begin
      glide_coef[i] = glide_step(glide_coef[i], target_coef[i], keep);
    end
    acc = glide_coef[COEF_B0] * xv
        + glide_coef[COEF_B1] * x_hist[0]
        + glide_coef[COEF_B2] * x_hist[1]
        - glide_coef[COEF_A1] * y_hist[0]
        - glide_coef[COEF_A2] * y_hist[1];
    // Round to nearest with ties upward, then clamp to [-2, 2).
    y = (acc + (longint'(1) << (COEFF_FRAC - 1))) >>> COEFF_FRAC;
    if (y > SAMPLE_MAX || y < SAMPLE_MIN) begin
      saturated_count++;
      y = (y > SAMPLE_MAX) ? SAMPLE_MAX : SAMPLE_MIN;
    end
    x_hist[1] = x_hist[0];
    x_hist[0] = xv;
    y_hist[1] = y_hist[0];
    y_hist[0] = y;
    return sample_t'(y);
  endfunction

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 4);
    if (pick < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 90);
  endfunction

  function automatic sample_t random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return sample_t'($urandom);
    if (pick < 8) return sample_t'(int'($urandom_range(0, 4000)) - 2000);
    case ($urandom_range(0, 4))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2:       return sample_t'(SAMPLE_ONE);
      3:       return sample_t'(-SAMPLE_ONE);
      default: return '0;
    endcase
  endfunction

  // Style 0 is a moderate filter, 1 the full range, 2 the corner values and
  // 3 moderate feedforward with corner-valued feedback.
  function automatic longint random_target(int unsigned style, bit feedback);
    if (style == 3) style = feedback ? 2 : 0;
    case (style)
      0: begin
        if (feedback) return longint'($urandom_range(0, 4 * COEF_ONE)) - 2 * COEF_ONE;
        return longint'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
      end
      1: return longint'($urandom_range(0, (1 << COEFF_W) - 1)) + COEF_MIN;
      default: begin
        case ($urandom_range(0, 4))
          0:       return COEF_MIN;
          1:       return COEF_MAX;
          2:       return COEF_ONE;
          3:       return -COEF_ONE;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  function automatic longint random_retention();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return S_ONE;
      2:       return $urandom_range(S_ONE + 1, RETAIN_TOP);
      3:       return $urandom_range(60000, S_ONE - 1);
      4:       return $urandom_range(0, S_ONE - 1);
      default: return ($urandom_range(0, 1) != 0) ? RETAIN_TOP : SMOOTH_RESET;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes and sample queueing, called just after a rising edge
  // ---------------------------------------------------------------------------

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    apply_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic configure(longint b0, longint b1, longint b2, longint a1, longint a2,
                           longint keep);
    write_reg(REG_TARGET_B0, cfg_word_t'(b0));
    write_reg(REG_TARGET_B1, cfg_word_t'(b1));
    write_reg(REG_TARGET_B2, cfg_word_t'(b2));
    write_reg(REG_TARGET_A1, cfg_word_t'(a1));
    write_reg(REG_TARGET_A2, cfg_word_t'(a2));
    write_reg(REG_SMOOTHING, cfg_word_t'(keep));
    settings_count++;
  endtask

  task automatic queue_sample(longint value);
    pending_samples.push_back(SAMPLE_W'(value));
  endtask

  // Waits until every queued sample has come back, then lets the pipe settle.
  task automatic drain();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0)
      @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, sample_t want, sample_t got);
    mismatch_count++;
    if (mismatch_count <= 20)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: takes samples from the pending queue, with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outputs.push_back(filter_sample(sample_t'(s_axis_tdata[SAMPLE_W-1:0])));
        samples_sent++;
        next_valid = 1'b0;
        // Every fourth stretch of 128 requests runs without gaps.
        send_gap = (((samples_sent / 128) % 4) != 3) ? draw_gap() : 0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() != 0) begin
          s_axis_tdata <= DATA_W'(pending_samples.pop_front());
          next_valid = 1'b1;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls and one long hold-off to fill the block
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) taken_count++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && taken_count >= 300 && s_axis_tvalid) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (((taken_count / 100) % 5) != 4 && $urandom_range(0, 3) == 0)
          stall_left = draw_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch("result with no sample pending", '0,
                        sample_t'(m_axis_tdata[SAMPLE_W-1:0]));
      end else if (m_axis_tdata[SAMPLE_W-1:0] !== expected_outputs[0]) begin
        report_mismatch("sample_out", expected_outputs[0],
                        sample_t'(m_axis_tdata[SAMPLE_W-1:0]));
        void'(expected_outputs.pop_front());
      end else begin
        void'(expected_outputs.pop_front());
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when no request moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned queued;
    int unsigned batch;
    int unsigned style;

    reset_filter_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default coefficients pass the input through: field extremes and patterns.
    queue_sample(0);
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    queue_sample(1);
    queue_sample(-1);
    queue_sample(longint'(24'h555555));
    queue_sample(longint'(sample_t'(24'hAAAAAA)));
    drain();

    // Zero retention jumps b0 to one half: odd inputs land on rounding ties.
    configure(COEF_ONE / 2, 0, 0, 0, 0, 0);
    cfg_we_i <= 1'b0;
    queue_sample(1);
    queue_sample(-1);
    queue_sample(3);
    queue_sample(-3);
    drain();

    // Gain of two: an exact +2.0 clamps to the largest code, -2.0 is exact.
    configure(2 * COEF_ONE, 0, 0, 0, 0, 0);
    cfg_we_i <= 1'b0;
    queue_sample(SAMPLE_ONE);
    queue_sample(-SAMPLE_ONE);
    queue_sample(SAMPLE_MAX);
    drain();

    // Corner-valued targets drive the sum into saturation both ways.
    configure(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 0);
    cfg_we_i <= 1'b0;
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    drain();

    // Retention above one holds the coefficients; unmapped indexes are ignored.
    configure(COEF_ONE, COEF_ONE, 0, 0, 0, RETAIN_TOP);
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, cfg_word_t'($urandom));
    cfg_we_i <= 1'b0;
    queue_sample(SAMPLE_ONE);
    queue_sample(-5);
    queue_sample(12345);
    drain();

    // Retention of exactly one also holds.
    configure(0, 0, 0, 0, 0, S_ONE);
    cfg_we_i <= 1'b0;
    queue_sample(SAMPLE_ONE);
    queue_sample(-SAMPLE_ONE);
    drain();

    // Random settings, each followed by a batch of random samples.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      style = $urandom_range(0, 3);
      configure(random_target(style, 1'b0), random_target(style, 1'b0),
                random_target(style, 1'b0), random_target(style, 1'b1),
                random_target(style, 1'b1), random_retention());
      cfg_we_i <= 1'b0;
      batch = $urandom_range(80, 220);
      for (int i = 0; i < batch; i++) queue_sample(random_sample());
      queued += batch;
      drain();
    end

    $display("Run covered %0d samples over %0d coefficient settings.",
             samples_sent, settings_count);
    $display("%0d outputs hit the saturation limits; %0d mismatches.",
             saturated_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/scbq_pkg.sv
rtl/core/scbq_ucode_rom.sv
rtl/core/scbq_sequencer.sv
rtl/core/scbq_datapath.sv
rtl/core/smoothed_coeff_biquad_filter.sv
tb/sv/testbench.sv
